@@ rtl/qxmm_pkg.sv @@
// Shared constants, register codes and pipeline stage types for the X-frame motor mixer.
`timescale 1ns / 1ps
`default_nettype none
package qxmm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;

    localparam int IN_W   = 16;              // command and throttle fields
    localparam int OUT_W  = 15;              // motor drive fields
    localparam int CFG_W  = 15;              // widest configuration register
    localparam int ADDR_W = 3;

    localparam int IN_TDATA_W  = ((4 * IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((4 * OUT_W + 7) / 8) * 8;

    localparam int TW    = FRAC_BITS + 1;    // throttle 0..ONE
    localparam int HW    = FRAC_BITS;        // headroom 0..ONE/2
    localparam int CMD_W = IN_W + 1;         // command after optional negation
    localparam int COR_W = CMD_W + 2;        // sum of three commands
    localparam int MAG_W = COR_W - 1;        // magnitude of a correction
    localparam int QW    = FRAC_BITS;        // scaled magnitude never exceeds headroom
    localparam int NW    = MAG_W + HW;       // product magnitude * headroom
    localparam int VW    = COR_W + 1;        // correction plus throttle

    typedef enum logic [ADDR_W-1:0] {
        REG_MIN_THR   = 3'd0,
        REG_IDLE_LVL  = 3'd1,
        REG_ROLL_INV  = 3'd2,
        REG_PITCH_INV = 3'd3,
        REG_YAW_INV   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic                       idle;
        logic [TW-1:0]              thr;
        logic [3:0][COR_W-1:0]      cor;
    } front_t;

    typedef struct packed {
        logic                       idle;
        logic [TW-1:0]              thr;
        logic [HW-1:0]              hdr;
        logic [3:0]                 neg;
        logic [3:0][COR_W-1:0]      cor;
        logic [3:0][MAG_W-1:0]      mag;
        logic [MAG_W-1:0]           mag_max;
    } mag_t;

    typedef struct packed {
        logic                       idle;
        logic                       scale;
        logic [TW-1:0]              thr;
        logic [MAG_W-1:0]           div;
        logic [3:0]                 neg;
        logic [3:0][COR_W-1:0]      cor;
        logic [3:0][NW-1:0]         rem;
        logic [3:0][QW-1:0]         quo;
    } div_stage_t;

    typedef struct packed {
        logic                       idle;
        logic [3:0][VW-1:0]         v;
    } sum_t;

    typedef struct packed {
        logic                       idle;
        logic [3:0][VW:0]           v;
    } shift_t;

endpackage
`default_nettype wire

@@ rtl/quad_x_motor_mixer.sv @@
// Top level of the quadcopter X-frame motor mixer pipeline.
// Usage:
//   Input stream s_axis_*: one request per beat carrying throttle, roll, pitch and yaw,
//   each signed Q2.14. Output stream m_axis_*: one beat per request with the four motor
//   drives, unsigned 0..16384. Configuration is a plain write port (cfg_we, cfg_addr,
//   cfg_wdata); write it only while no request is in flight.
//   Throughput: one request per cycle, sustained unless the receiver holds m_axis_tready low.
//   The pipeline has 20 register stages: front end, magnitude/max, multiply, 14 restoring
//   divider stages (one quotient bit each, four lanes side by side), then add, shift-down
//   and shift-up/clamp.
//   When the receiver holds m_axis_tready low with a result waiting, the whole pipeline
//   freezes and s_axis_tready drops in the same cycle; nothing is lost or repeated.
//   Reset empties the pipeline and loads min_throttle 0, idle_level 0, roll_invert 0,
//   pitch_invert 1 and yaw_invert 1.
`timescale 1ns / 1ps
`default_nettype none
module quad_x_motor_mixer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // throttle_in, roll_cmd, pitch_cmd, yaw_cmd (16 bits each, lowest first)
    input  wire logic [qxmm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // motor_front_right, motor_rear_left, motor_front_left, motor_rear_right
    // (15 bits each, lowest first), zero padding on top
    output logic [qxmm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [qxmm_pkg::ADDR_W-1:0]       cfg_addr,
    input  wire logic [qxmm_pkg::CFG_W-1:0]        cfg_wdata
);
    import qxmm_pkg::*;

    localparam int NST  = QW + 6;
    localparam int ST_A = QW + 3;
    localparam int ST_B = QW + 4;

    // configuration
    logic [CFG_W-1:0] min_thr_reg;
    logic [CFG_W-1:0] idle_lvl_reg;
    logic             roll_inv_reg;
    logic             pitch_inv_reg;
    logic             yaw_inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_thr_reg   <= '0;
            idle_lvl_reg  <= '0;
            roll_inv_reg  <= 1'b0;
            pitch_inv_reg <= 1'b1;
            yaw_inv_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_MIN_THR:   min_thr_reg   <= cfg_wdata;
                REG_IDLE_LVL:  idle_lvl_reg  <= cfg_wdata;
                REG_ROLL_INV:  roll_inv_reg  <= cfg_wdata[0];
                REG_PITCH_INV: pitch_inv_reg <= cfg_wdata[0];
                REG_YAW_INV:   yaw_inv_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [NST-1:0] vld_reg;
    logic           adv;

    assign adv           = !vld_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
        end
    end

    // stage 0: clamp throttle, apply axis signs, form X-frame corrections
    front_t front_reg, front_next;

    logic signed [IN_W-1:0]  thr_raw;
    logic [TW-1:0]           thr_c;
    logic signed [CMD_W-1:0] r_cmd, p_cmd, y_cmd;
    logic signed [COR_W-1:0] rx, px, yx;

    always_comb
    begin
        thr_raw = $signed(s_axis_tdata[IN_W-1:0]);
        if (thr_raw < 0)
            thr_c = '0;
        else if (thr_raw > $signed(IN_W'(ONE)))
            thr_c = TW'(ONE);
        else
            thr_c = thr_raw[TW-1:0];

        r_cmd = $signed({s_axis_tdata[2*IN_W-1], s_axis_tdata[2*IN_W-1:IN_W]});
        p_cmd = $signed({s_axis_tdata[3*IN_W-1], s_axis_tdata[3*IN_W-1:2*IN_W]});
        y_cmd = $signed({s_axis_tdata[4*IN_W-1], s_axis_tdata[4*IN_W-1:3*IN_W]});
        if (roll_inv_reg)
            r_cmd = -r_cmd;
        if (pitch_inv_reg)
            p_cmd = -p_cmd;
        if (yaw_inv_reg)
            y_cmd = -y_cmd;
        rx = COR_W'(r_cmd);
        px = COR_W'(p_cmd);
        yx = COR_W'(y_cmd);

        front_next.idle   = ((CFG_W + 1)'(thr_c) <= (CFG_W + 1)'(min_thr_reg));
        front_next.thr    = thr_c;
        front_next.cor[0] = -rx + px + yx;   // front right
        front_next.cor[1] =  rx - px + yx;   // rear left
        front_next.cor[2] =  rx + px - yx;   // front left
        front_next.cor[3] = -rx - px - yx;   // rear right
    end

    // stage 1: magnitudes, largest magnitude, headroom
    mag_t mag_reg, mag_next;

    logic [MAG_W-1:0] max01, max23;
    logic [TW-1:0]    top_room;

    always_comb
    begin
        mag_next.idle = front_reg.idle;
        mag_next.thr  = front_reg.thr;
        mag_next.cor  = front_reg.cor;
        for (int i = 0; i < 4; i++)
        begin
            mag_next.neg[i] = front_reg.cor[i][COR_W-1];
            mag_next.mag[i] = front_reg.cor[i][COR_W-1]
                            ? MAG_W'(-$signed(front_reg.cor[i]))
                            : front_reg.cor[i][MAG_W-1:0];
        end
        max01 = (mag_next.mag[0] > mag_next.mag[1]) ? mag_next.mag[0] : mag_next.mag[1];
        max23 = (mag_next.mag[2] > mag_next.mag[3]) ? mag_next.mag[2] : mag_next.mag[3];
        mag_next.mag_max = (max01 > max23) ? max01 : max23;

        top_room     = TW'(ONE) - front_reg.thr;
        mag_next.hdr = (front_reg.thr < top_room) ? front_reg.thr[HW-1:0] : top_room[HW-1:0];
    end

    // stage 2: product magnitude * headroom; stages 3..QW+2: one quotient bit each
    div_stage_t div_reg  [0:QW];
    div_stage_t div_next [0:QW];

    logic [NW-1:0] dsh [1:QW];

    always_comb
    begin
        div_next[0].idle  = mag_reg.idle;
        div_next[0].scale = (mag_reg.mag_max > MAG_W'(mag_reg.hdr));
        div_next[0].thr   = mag_reg.thr;
        div_next[0].div   = mag_reg.mag_max;
        div_next[0].neg   = mag_reg.neg;
        div_next[0].cor   = mag_reg.cor;
        div_next[0].quo   = '0;
        for (int i = 0; i < 4; i++)
        begin
            div_next[0].rem[i] = NW'(mag_reg.mag[i]) * NW'(mag_reg.hdr);
        end

        for (int k = 1; k <= QW; k++)
        begin
            div_next[k] = div_reg[k-1];
            dsh[k]      = NW'(div_reg[k-1].div) << (QW - k);
            for (int i = 0; i < 4; i++)
            begin
                if (div_reg[k-1].rem[i] >= dsh[k])
                begin
                    div_next[k].rem[i]        = div_reg[k-1].rem[i] - dsh[k];
                    div_next[k].quo[i][QW-k]  = 1'b1;
                end
            end
        end
    end

    // stage A: restore sign of scaled corrections, use them only when scaling applies, add throttle
    sum_t sum_reg, sum_next;

    logic signed [COR_W-1:0] q_s  [4];
    logic signed [COR_W-1:0] c_f  [4];

    always_comb
    begin
        sum_next.idle = div_reg[QW].idle;
        for (int i = 0; i < 4; i++)
        begin
            q_s[i] = $signed({{(COR_W - QW){1'b0}}, div_reg[QW].quo[i]});
            if (div_reg[QW].neg[i])
                q_s[i] = -q_s[i];
            c_f[i] = div_reg[QW].scale ? q_s[i] : $signed(div_reg[QW].cor[i]);
            sum_next.v[i] = VW'(c_f[i]) + $signed({{(VW - TW){1'b0}}, div_reg[QW].thr});
        end
    end

    // stage B: shift all down when one is above full scale
    shift_t shift_reg, shift_next;

    logic signed [VW-1:0] hi01, hi23, hi;
    logic signed [VW:0]   over;

    always_comb
    begin
        hi01 = ($signed(sum_reg.v[0]) > $signed(sum_reg.v[1])) ? sum_reg.v[0] : sum_reg.v[1];
        hi23 = ($signed(sum_reg.v[2]) > $signed(sum_reg.v[3])) ? sum_reg.v[2] : sum_reg.v[3];
        hi   = (hi01 > hi23) ? hi01 : hi23;
        over = (hi > $signed(VW'(ONE))) ? ((VW + 1)'(hi) - $signed((VW + 1)'(ONE))) : '0;
        shift_next.idle = sum_reg.idle;
        for (int i = 0; i < 4; i++)
        begin
            shift_next.v[i] = (VW + 1)'($signed(sum_reg.v[i])) - over;
        end
    end

    // stage C: shift all up when one is below zero, clamp, pick idle level
    logic [OUT_TDATA_W-1:0] out_reg, out_next;

    logic signed [VW:0]   lo01, lo23, lo;
    logic signed [VW+1:0] vu   [4];
    logic [TW-1:0]        drv  [4];
    logic [TW-1:0]        idle_c;

    always_comb
    begin
        lo01 = ($signed(shift_reg.v[0]) < $signed(shift_reg.v[1]))
             ? shift_reg.v[0] : shift_reg.v[1];
        lo23 = ($signed(shift_reg.v[2]) < $signed(shift_reg.v[3]))
             ? shift_reg.v[2] : shift_reg.v[3];
        lo   = (lo01 < lo23) ? lo01 : lo23;
        idle_c = (idle_lvl_reg > CFG_W'(ONE)) ? TW'(ONE) : TW'(idle_lvl_reg);
        for (int i = 0; i < 4; i++)
        begin
            vu[i] = (VW + 2)'($signed(shift_reg.v[i]));
            if (lo < 0)
                vu[i] = vu[i] - (VW + 2)'(lo);
            if (vu[i] < 0)
                drv[i] = '0;
            else if (vu[i] > $signed((VW + 2)'(ONE)))
                drv[i] = TW'(ONE);
            else
                drv[i] = vu[i][TW-1:0];
            if (shift_reg.idle)
                drv[i] = idle_c;
        end
        out_next = {{(OUT_TDATA_W - 4 * OUT_W){1'b0}},
                    OUT_W'(drv[3]), OUT_W'(drv[2]), OUT_W'(drv[1]), OUT_W'(drv[0])};
    end

    // payload registers: advance together with the valid bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            front_reg <= front_next;
            mag_reg   <= mag_next;
            for (int k = 0; k <= QW; k++)
            begin
                div_reg[k] <= div_next[k];
            end
            sum_reg   <= sum_next;
            shift_reg <= shift_next;
            out_reg   <= out_next;
        end
    end

    assign m_axis_tdata = out_reg;

    // checks
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> vld_reg == $past(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_accept_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
        else $error("accepted request did not enter the first stage");

    a_sum_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_A] && !sum_reg.idle) |->
            ($signed(sum_reg.v[0]) >= 0 && $signed(sum_reg.v[0]) <= $signed(VW'(ONE)) &&
             $signed(sum_reg.v[1]) >= 0 && $signed(sum_reg.v[1]) <= $signed(VW'(ONE)) &&
             $signed(sum_reg.v[2]) >= 0 && $signed(sum_reg.v[2]) <= $signed(VW'(ONE)) &&
             $signed(sum_reg.v[3]) >= 0 && $signed(sum_reg.v[3]) <= $signed(VW'(ONE))))
        else $error("scaled correction plus throttle left the unit range");

    a_shift_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_B] && !shift_reg.idle) |->
            ($signed(shift_reg.v[0]) >= 0 && $signed(shift_reg.v[1]) >= 0 &&
             $signed(shift_reg.v[2]) >= 0 && $signed(shift_reg.v[3]) >= 0))
        else $error("downward shift pushed a motor below zero");

    a_out_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[OUT_W-1:0]         <= OUT_W'(ONE) &&
             m_axis_tdata[2*OUT_W-1:OUT_W]   <= OUT_W'(ONE) &&
             m_axis_tdata[3*OUT_W-1:2*OUT_W] <= OUT_W'(ONE) &&
             m_axis_tdata[4*OUT_W-1:3*OUT_W] <= OUT_W'(ONE)))
        else $error("motor drive above full scale");

endmodule
`default_nettype wire
